[sv/keyframe_matrix_interpolator_top_defines.svh]
`ifndef KEYFRAME_MATRIX_INTERPOLATOR_TOP_DEFINES_SVH
`define KEYFRAME_MATRIX_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define KMI_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define KMI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/kmi_pkg.sv]
`default_nettype none

package kmi_pkg;

    localparam int KEYS_DEFAULT   = 64;
    localparam int ELEMS          = 16;
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int DIV_STEPS      = 16;

    localparam logic [16:0] Q_ONE           = 17'h10000;
    localparam logic [6:0]  KEY_COUNT_RESET = 7'd1;

    localparam logic [1:0] FUNC_WR_TIME = 2'd0;
    localparam logic [1:0] FUNC_WR_ELEM = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE  = 2'd2;

    typedef enum logic [1:0] {
        OP_WR_TIME = 2'd0,
        OP_WR_ELEM = 2'd1,
        OP_SAMPLE  = 2'd2
    } t_op;

    // data is the element value for OP_WR_ELEM, the time otherwise
    typedef struct packed {
        t_op         op;
        logic [5:0]  key;
        logic [3:0]  elem;
        logic [31:0] data;
    } t_cmd;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

[sv/kmi_ifs.sv]
`default_nettype none

interface kmi_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  func;
    logic        [5:0]  key_index;
    logic        [3:0]  element_index;
    logic signed [31:0] element_value;
    logic        [31:0] time_value;

    modport source (
        output valid, func, key_index, element_index, element_value, time_value,
        input  ready
    );
    modport sink (
        input  valid, func, key_index, element_index, element_value, time_value,
        output ready
    );
endinterface

interface kmi_out_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  out_index;
    logic signed [31:0] out_value;
    logic               last;

    modport source (
        output valid, out_index, out_value, last,
        input  ready
    );
    modport sink (
        input  valid, out_index, out_value, last,
        output ready
    );
endinterface

`default_nettype wire

[sv/kmi_front.sv]
`default_nettype none

module kmi_front
    import kmi_pkg::*;
#(
    parameter int KEYS = KEYS_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kmi_in_if.sink     i_in,
    output logic       o_cmd_valid,
    input  wire logic  i_cmd_ready,
    output t_cmd       o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    logic keep;
    t_cmd cmd;
    logic key_ok;

    assign key_ok = 32'(i_in.key_index) < KEYS;

    // unused func codes and writes past the table are taken and dropped here
    always_comb begin
        keep      = 1'b0;
        cmd.op    = OP_SAMPLE;
        cmd.key   = i_in.key_index;
        cmd.elem  = i_in.element_index;
        cmd.data  = i_in.time_value;
        unique case (i_in.func)
            FUNC_WR_TIME: begin
                cmd.op = OP_WR_TIME;
                keep   = key_ok;
            end
            FUNC_WR_ELEM: begin
                cmd.op   = OP_WR_ELEM;
                cmd.data = i_in.element_value;
                keep     = key_ok;
            end
            FUNC_SAMPLE: begin
                cmd.op = OP_SAMPLE;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign i_in.ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= keep;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= cmd;
        end
    end

endmodule

`default_nettype wire

[sv/kmi_cmd_fifo.sv]
`default_nettype none

module kmi_cmd_fifo
    import kmi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_cmd  i_push_cmd,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_cmd       o_pop_cmd
);

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);

    t_cmd             r_mem [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count < (PTR_W+1)'(CMD_FIFO_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

[sv/kmi_divider.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle: floor(dividend * 2^16 / divisor).
// Caller guarantees dividend < divisor, so the quotient fits 16 bits.
module kmi_divider
    import kmi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [31:0]      r_div;
    logic [15:0]      r_q;
    logic [32:0]      rem_sh;
    logic [32:0]      rem_sub;
    logic             ge;

    assign rem_sh  = {r_rem, 1'b0};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign ge      = rem_sh >= {1'b0, r_div};

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_div <= i_req.divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
            r_q   <= {r_q[14:0], ge};
        end
    end

endmodule

`default_nettype wire

[sv/kmi_back.sv]
`default_nettype none

`include "keyframe_matrix_interpolator_top_defines.svh"

module kmi_back
    import kmi_pkg::*;
#(
    parameter int KEYS = KEYS_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    output logic            o_cmd_ready,
    input  wire t_cmd       i_cmd,
    input  wire logic [6:0] i_key_count,
    kmi_out_if.source       o_out
);

    localparam int IDX_W  = $clog2(KEYS);
    localparam int CNT_W  = $clog2(KEYS + 1);
    localparam int MA_W   = IDX_W + $clog2(ELEMS);
    localparam int PROD_W = 51;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_SCAN_RD  = 12'b000000000010,
        S_SCAN_CHK = 12'b000000000100,
        S_RD_PREV  = 12'b000000001000,
        S_RD_NEXT  = 12'b000000010000,
        S_SPAN     = 12'b000000100000,
        S_RATIO    = 12'b000001000000,
        S_DIV      = 12'b000010000000,
        S_EL_RD    = 12'b000100000000,
        S_EL_DIFF  = 12'b001000000000,
        S_EL_MUL   = 12'b010000000000,
        S_EL_OUT   = 12'b100000000000
    } t_state;

    // key tables
    logic [31:0] m_time [KEYS];
    logic [31:0] m_mat  [KEYS*ELEMS];
    logic [31:0] r_time_rd;
    logic [31:0] r_mat_a;
    logic [31:0] r_mat_b;

    t_state                    r_state,     n_state;
    logic        [CNT_W-1:0]   r_idx,       n_idx;
    logic        [IDX_W-1:0]   r_prev,      n_prev;
    logic        [IDX_W-1:0]   r_next,      n_next;
    logic        [31:0]        r_t,         n_t;
    logic        [31:0]        r_tprev,     n_tprev;
    logic        [31:0]        r_elapsed,   n_elapsed;
    logic signed [32:0]        r_span,      n_span;
    logic        [16:0]        r_ratio,     n_ratio;
    logic        [3:0]         r_el,        n_el;
    logic signed [31:0]        r_a,         n_a;
    logic signed [32:0]        r_diff,      n_diff;
    logic signed [PROD_W-1:0]  r_prod,      n_prod;
    logic                      r_out_valid, n_out_valid;
    logic        [3:0]         r_out_idx,   n_out_idx;
    logic signed [31:0]        r_out_val,   n_out_val;
    logic                      r_out_last,  n_out_last;

    logic [CNT_W-1:0] key_n;
    logic [CNT_W-1:0] key_n_m1;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] prev_inc;
    logic [IDX_W-1:0] time_ra;
    logic [IDX_W-1:0] wr_key;
    logic             time_we;
    logic             mat_we;
    logic             span_pos;
    logic             out_load;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [34:0]       sum;
    logic signed [31:0]       sat;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // zero keys act as one, more than the table holds act as the table size
    always_comb begin
        if (i_key_count == '0) begin
            key_n = CNT_W'(1);
        end else if (32'(i_key_count) > KEYS) begin
            key_n = CNT_W'(KEYS);
        end else begin
            key_n = CNT_W'(i_key_count);
        end
    end

    assign key_n_m1 = key_n - CNT_W'(1);
    assign idx_inc  = r_idx + CNT_W'(1);
    assign prev_inc = CNT_W'(r_prev) + CNT_W'(1);
    assign wr_key   = IDX_W'(i_cmd.key);
    assign span_pos = !r_span[32] && (r_span != '0);

    assign o_cmd_ready = r_state == S_IDLE;
    assign time_we     = o_cmd_ready && i_cmd_valid && (i_cmd.op == OP_WR_TIME);
    assign mat_we      = o_cmd_ready && i_cmd_valid && (i_cmd.op == OP_WR_ELEM);

    always_comb begin
        priority if (r_state == S_RD_PREV) begin
            time_ra = r_prev;
        end else if (r_state == S_RD_NEXT) begin
            time_ra = r_next;
        end else begin
            time_ra = r_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (time_we) begin
            m_time[wr_key] <= i_cmd.data;
        end
        r_time_rd <= m_time[time_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            m_mat[{wr_key, i_cmd.elem}] <= i_cmd.data;
        end
        r_mat_a <= m_mat[MA_W'({r_prev, r_el})];
        r_mat_b <= m_mat[MA_W'({r_next, r_el})];
    end

    assign div_req.start    = (r_state == S_RATIO) && span_pos
                              && ({1'b0, r_elapsed} < r_span);
    assign div_req.dividend = r_elapsed;
    assign div_req.divisor  = r_span[31:0];

    kmi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // a + floor(diff * ratio / 2^16), saturated
    assign prod_sh = r_prod >>> 16;
    assign sum     = $signed({{3{r_a[31]}}, r_a}) + $signed(prod_sh[34:0]);

    always_comb begin
        if (sum[34] && !(&sum[33:31])) begin
            sat = 32'sh80000000;
        end else if (!sum[34] && (|sum[33:31])) begin
            sat = 32'sh7FFFFFFF;
        end else begin
            sat = sum[31:0];
        end
    end

    assign out_load = (r_state == S_EL_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_next      = r_next;
        n_t         = r_t;
        n_tprev     = r_tprev;
        n_elapsed   = r_elapsed;
        n_span      = r_span;
        n_ratio     = r_ratio;
        n_el        = r_el;
        n_a         = r_a;
        n_diff      = r_diff;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_idx   = r_out_idx;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_SAMPLE) begin
                    n_t     = i_cmd.data;
                    n_idx   = '0;
                    n_prev  = key_n_m1[IDX_W-1:0];
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                // stop at the first key later than the sample time
                if (r_time_rd > r_t) begin
                    n_state = S_RD_PREV;
                end else begin
                    n_prev = r_idx[IDX_W-1:0];
                    if (idx_inc == key_n) begin
                        n_state = S_RD_PREV;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_RD_PREV: begin
                n_next  = (prev_inc == key_n) ? '0 : prev_inc[IDX_W-1:0];
                n_state = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                n_tprev = r_time_rd;
                n_state = S_SPAN;
            end
            S_SPAN: begin
                n_elapsed = (r_t >= r_tprev) ? (r_t - r_tprev) : '0;
                n_span    = $signed({1'b0, r_time_rd}) - $signed({1'b0, r_tprev});
                n_state   = S_RATIO;
            end
            S_RATIO: begin
                n_el = '0;
                if (!span_pos) begin
                    n_ratio = '0;
                    n_state = S_EL_RD;
                end else if ({1'b0, r_elapsed} >= r_span) begin
                    n_ratio = Q_ONE;
                    n_state = S_EL_RD;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_ratio = {1'b0, div_rsp.quotient};
                    n_state = S_EL_RD;
                end
            end
            S_EL_RD: begin
                n_state = S_EL_DIFF;
            end
            S_EL_DIFF: begin
                n_a     = r_mat_a;
                n_diff  = $signed({r_mat_b[31], r_mat_b}) - $signed({r_mat_a[31], r_mat_a});
                n_state = S_EL_MUL;
            end
            S_EL_MUL: begin
                n_prod  = $signed({{18{r_diff[32]}}, r_diff})
                          * $signed({34'b0, r_ratio});
                n_state = S_EL_OUT;
            end
            S_EL_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_el;
                    n_out_val   = sat;
                    n_out_last  = r_el == 4'(ELEMS - 1);
                    if (r_el == 4'(ELEMS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_el    = r_el + 4'd1;
                        n_state = S_EL_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_prev     <= n_prev;
        r_next     <= n_next;
        r_t        <= n_t;
        r_tprev    <= n_tprev;
        r_elapsed  <= n_elapsed;
        r_span     <= n_span;
        r_ratio    <= n_ratio;
        r_el       <= n_el;
        r_a        <= n_a;
        r_diff     <= n_diff;
        r_prod     <= n_prod;
        r_out_idx  <= n_out_idx;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_index = r_out_idx;
    assign o_out.out_value = r_out_val;
    assign o_out.last      = r_out_last;

    `KMI_ASSERT_IMPL(a_last_on_final, i_clk, i_rst_n, r_out_valid, r_out_last == (r_out_idx == 4'(ELEMS - 1)), "last flag does not match element index")
    `KMI_ASSERT_IMPL(a_ratio_range, i_clk, i_rst_n, r_state == S_EL_MUL, r_ratio <= Q_ONE, "ratio above one")
    `KMI_ASSERT_IMPL(a_div_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV, "divider result with no wait pending")
    `KMI_ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN_CHK, r_idx < key_n, "scan index past key count")
    `KMI_ASSERT_NEXT(a_final_to_idle, i_clk, i_rst_n, out_load && (r_el == 4'(ELEMS - 1)), r_state == S_IDLE, "sample did not finish after last element")

endmodule

`default_nettype wire

[sv/keyframe_matrix_interpolator_top.sv]
// Write items (key time, key element): one transfer per cycle sustained while no sample is
// in progress, no result. Sample: scan the keys, fetch both key times and compare, run the
// serial divider when the ratio needs it, then emit each element with the output ready;
// 16 results per sample, and a new sample starts only after the last of them is issued;
// a 2-entry command queue decouples input.
// Reset (synchronous, active low) clears control, sets key_count to 1, leaves key tables.
`default_nettype none

module keyframe_matrix_interpolator_top
    import kmi_pkg::*;
#(
    parameter int KEYS = KEYS_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_data,
    kmi_in_if.sink          i_in,
    kmi_out_if.source       o_out
);

    logic [6:0] r_key_count;
    logic       front_valid;
    logic       front_ready;
    t_cmd       front_cmd;
    logic       queue_valid;
    logic       queue_ready;
    t_cmd       queue_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEY_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_key_count <= i_cfg_data;
        end
    end

    kmi_front #(
        .KEYS (KEYS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    kmi_cmd_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_cmd    (queue_cmd)
    );

    kmi_back #(
        .KEYS (KEYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .i_key_count (r_key_count),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kmi_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam longint SAT_HI     = 64'sd2147483647;
    localparam longint SAT_LO     = -64'sd2147483648;

    typedef struct {
        bit [1:0]  func;
        bit [5:0]  key;
        bit [3:0]  elem;
        bit [31:0] value;
        bit [31:0] stamp;
    } t_kmi_item;

    typedef struct {
        bit [3:0]         index;
        bit signed [31:0] value;
        bit               last;
    } t_elem_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_data;

    kmi_in_if  in_if ();
    kmi_out_if out_if ();

    keyframe_matrix_interpolator_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // items waiting to be driven, and the generator's view of the key table
    t_kmi_item    item_q [$];
    bit [31:0]    plan_times [KEYS_DEFAULT];
    bit [15:0]    plan_loaded [KEYS_DEFAULT];

    // predictor state, updated on each accepted transfer
    bit [31:0]        key_times [KEYS_DEFAULT];
    bit signed [31:0] key_mats [KEYS_DEFAULT][ELEMS];
    bit [6:0]         key_count_now = KEY_COUNT_RESET;
    t_elem_result     pending_elems [$];
    t_elem_result     head_elem;

    int src_gap_pct;
    int sink_stall_pct;
    bit hold_arm;
    bit hold_done;
    int hold_left;
    int quiet_cycles;

    int mismatches;
    int n_samples;
    int n_writes;
    int n_unused;
    int n_results;
    int n_settings;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned keys_used(bit [6:0] setting);
        if (setting == 0) return 1;
        if (setting > KEYS_DEFAULT) return KEYS_DEFAULT;
        return 32'(setting);
    endfunction

    function automatic void interpolate_sample(bit [31:0] t);
        int unsigned n, prev, nxt;
        bit stop;
        longint elapsed, span, ratio, a, b, v;
        t_elem_result r;
        n = keys_used(key_count_now);
        prev = n - 1;
        stop = 1'b0;
        // last key not beyond t, scanning stops at the first later key
        for (int i = 0; i < n; i++) begin
            if (!stop) begin
                if (key_times[i] > t) stop = 1'b1;
                else prev = i;
            end
        end
        nxt = (prev + 1) % n;
        elapsed = longint'({32'd0, t}) - longint'({32'd0, key_times[prev]});
        if (elapsed < 0) elapsed = 0;
        span = longint'({32'd0, key_times[nxt]}) - longint'({32'd0, key_times[prev]});
        if (span <= 0) ratio = 0;
        else if (elapsed >= span) ratio = longint'(Q_ONE);
        else ratio = (elapsed << 16) / span;
        for (int e = 0; e < ELEMS; e++) begin
            a = longint'(key_mats[prev][e]);
            b = longint'(key_mats[nxt][e]);
            v = a + (((b - a) * ratio) >>> 16);
            if (v > SAT_HI) v = SAT_HI;
            if (v < SAT_LO) v = SAT_LO;
            r.index = 4'(e);
            r.value = v[31:0];
            r.last  = (e == ELEMS - 1);
            pending_elems = {pending_elems, r};
        end
    endfunction

    function automatic void apply_item(t_kmi_item it);
        case (it.func)
            FUNC_WR_TIME: begin
                key_times[it.key] = it.stamp;
                n_writes++;
            end
            FUNC_WR_ELEM: begin
                key_mats[it.key][it.elem] = it.value;
                n_writes++;
            end
            FUNC_SAMPLE: begin
                interpolate_sample(it.stamp);
                n_samples++;
            end
            default: n_unused++;
        endcase
    endfunction

    function automatic void push_item(bit [1:0] f, bit [5:0] k, bit [3:0] e,
                                      bit [31:0] v, bit [31:0] t);
        t_kmi_item it;
        it.func  = f;
        it.key   = k;
        it.elem  = e;
        it.value = v;
        it.stamp = t;
        item_q = {item_q, it};
        if (f == FUNC_WR_TIME) plan_times[k] = t;
        if (f == FUNC_WR_ELEM) plan_loaded[k][e] = 1'b1;
    endfunction

    // unused fields of a sample or an unused-func item carry random bits
    function automatic void push_other(bit [1:0] f, bit [31:0] t);
        push_item(f, 6'($urandom_range(63)), 4'($urandom_range(15)), $urandom, t);
    endfunction

    function automatic void push_time(bit [5:0] k, bit [31:0] t);
        push_item(FUNC_WR_TIME, k, 4'($urandom_range(15)), $urandom, t);
    endfunction

    function automatic bit [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4: return $urandom_range(32'h3_FFFF) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    // offsets mostly around the first nine keys, the far end is reached by the extremes
    function automatic bit [31:0] pick_sample_time(int unsigned n, bit [31:0] mask);
        int unsigned j;
        bit [31:0] off;
        j = $urandom_range((n > 9) ? 8 : n - 1);
        off = $urandom & mask;
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            2: return plan_times[j];
            3: return plan_times[j] - 1;
            default: return $urandom_range(1) ? plan_times[j] + off : plan_times[j] - off;
        endcase
    endfunction

    // keys past the first eight sit at the end of time, so only the extremes scan them all
    function automatic void load_key_times(int unsigned n, int unsigned pat);
        bit [31:0] t;
        t = $urandom_range(32'h3FFF_FFFF);
        for (int k = 0; k < n; k++) begin
            case (pat)
                0: t = t + $urandom_range(1, 64);
                1: t = t + $urandom_range(1, 32'h00FF_FFFF);
                2: t = $urandom;
                default: t = t + $urandom_range(3) * $urandom_range(1, 200);  // repeats
            endcase
            if (k >= 8) t = 32'hFFFF_FFFF;
            push_time(6'(k), t);
        end
    endfunction

    function automatic void load_matrix(int unsigned k);
        for (int e = 0; e < ELEMS; e++) begin
            if (!plan_loaded[k][e]) push_item(FUNC_WR_ELEM, 6'(k), 4'(e), pick_value(), $urandom);
        end
    endfunction

    // both keys that the sample pairs must hold a full matrix before it reads them
    function automatic void push_sample(int unsigned n, bit [31:0] t);
        int unsigned prev, nxt;
        bit stop;
        prev = n - 1;
        stop = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!stop) begin
                if (plan_times[i] > t) stop = 1'b1;
                else prev = i;
            end
        end
        nxt = (prev + 1) % n;
        load_matrix(prev);
        load_matrix(nxt);
        push_other(FUNC_SAMPLE, t);
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (item_q.size() != 0 || in_if.valid || pending_elems.size() != 0);
        // writes may still sit in the command queue
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_key_count(bit [6:0] setting);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= setting;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_count_now = setting;
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic random_phase(bit [6:0] setting, int items, bit steady, bit squeeze);
        int unsigned n, pat, r;
        bit [5:0] k;
        bit [31:0] mask;
        set_key_count(setting);
        src_gap_pct    = steady ? 0 : 9;
        sink_stall_pct = steady ? 0 : 9;
        if (squeeze) hold_arm = 1'b1;
        n = keys_used(setting);
        pat = $urandom_range(3);
        case (pat)
            0: mask = 32'hFF;
            1: mask = 32'hFF_FFFF;
            2: mask = 32'hFFFF;
            default: mask = 32'h3FF;
        endcase
        load_key_times(n, pat);
        repeat (items) begin
            r = $urandom_range(99);
            if (r < 75) begin
                push_sample(n, pick_sample_time(n, mask));
            end else if (r < 86) begin
                push_item(FUNC_WR_ELEM, 6'($urandom_range(63)), 4'($urandom_range(15)),
                          pick_value(), $urandom);
            end else if (r < 93) begin
                k = 6'($urandom_range(63));
                push_time(k, plan_times[k] + ($urandom & mask));
            end else begin
                push_other(FUNC_UNUSED, $urandom);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) apply_item(item_q.pop_front());
            if (!in_if.valid || in_if.ready) begin
                if (item_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                    in_if.valid         <= 1'b1;
                    in_if.func          <= item_q[0].func;
                    in_if.key_index     <= item_q[0].key;
                    in_if.element_index <= item_q[0].elem;
                    in_if.element_value <= item_q[0].value;
                    in_if.time_value    <= item_q[0].stamp;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (pending_elems.size() == 0) begin
                    $error("result with nothing expected: out_index %0d out_value %0d",
                           out_if.out_index, out_if.out_value);
                    mismatches++;
                end else begin
                    head_elem = pending_elems.pop_front();
                    if (out_if.out_index !== head_elem.index) begin
                        $error("out_index: expected %0d, actual %0d",
                               head_elem.index, out_if.out_index);
                        mismatches++;
                    end
                    if (out_if.out_value !== head_elem.value) begin
                        $error("out_value (element %0d): expected %0d, actual %0d",
                               head_elem.index, head_elem.value, out_if.out_value);
                        mismatches++;
                    end
                    if (out_if.last !== head_elem.last) begin
                        $error("last (element %0d): expected %0d, actual %0d",
                               head_elem.index, head_elem.last, out_if.last);
                        mismatches++;
                    end
                end
            end
            // one long hold-off so the command queue backs up into the input
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else if (hold_arm && !hold_done) begin
                hold_left    <= HOLD_CYCLES;
                hold_done    <= 1'b1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        bit [6:0] plan [9];
        bit [31:0] v;
        plan = '{7'd2, 7'd3, 7'd1, 7'd5, 7'd8, 7'd0, 7'd127, 7'd4, 7'd6};
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = '0;
        in_if.valid          = 1'b0;
        in_if.func           = '0;
        in_if.key_index      = '0;
        in_if.element_index  = '0;
        in_if.element_value  = '0;
        in_if.time_value     = '0;
        out_if.ready         = 1'b0;
        src_gap_pct          = 9;
        sink_stall_pct       = 9;
        hold_arm             = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // four keys; keys 0 and 1 swap the signed extremes in elements 0 and 1
        push_time(0, 1000);
        push_time(1, 5000);
        push_time(2, 5000);
        push_time(3, 6000);
        for (int k = 0; k < 4; k++) begin
            for (int e = 0; e < ELEMS; e++) begin
                if ((k == 0 && e == 0) || (k == 1 && e == 1)) v = 32'h8000_0000;
                else if ((k == 1 && e == 0) || (k == 0 && e == 1)) v = 32'h7FFF_FFFF;
                else v = pick_value();
                push_item(FUNC_WR_ELEM, 6'(k), 4'(e), v, $urandom);
            end
        end
        // one key in use: matrix held as is
        push_other(FUNC_SAMPLE, 32'h0);
        push_other(FUNC_SAMPLE, 32'hFFFF_FFFF);
        push_other(FUNC_UNUSED, $urandom);
        push_other(FUNC_SAMPLE, 1000);
        set_key_count(7'd0);
        push_other(FUNC_SAMPLE, 2000);
        set_key_count(7'd4);
        push_other(FUNC_SAMPLE, 3000);          // halfway between extremes
        push_other(FUNC_SAMPLE, 4999);
        push_other(FUNC_SAMPLE, 999);           // before every key, span negative
        push_other(FUNC_SAMPLE, 5000);
        push_other(FUNC_SAMPLE, 7000);          // wraps to key 0, span negative
        push_other(FUNC_SAMPLE, 32'hFFFF_FFFF);
        push_time(3, 200);
        push_other(FUNC_SAMPLE, 999);           // no key qualifies, last key interpolates
        push_other(FUNC_SAMPLE, 100);           // elapsed negative, ratio zero
        push_other(FUNC_SAMPLE, 32'hFFFF_FFFF); // ratio clamped to one
        push_time(3, 1000);
        push_other(FUNC_SAMPLE, 5500);          // zero span at the wrap

        foreach (plan[p]) begin
            random_phase(plan[p], 11, p == 3, p == 7);
        end
        wait_idle();

        $display("Run covered %0d samples, %0d key writes and %0d unused-func items;",
                 n_samples, n_writes, n_unused);
        $display("%0d results checked over %0d key-count writes (0 through 127), %0d mismatches",
                 n_results, n_settings, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
